[design/grf_pkg.sv]
// ----------------------------------------------------------------------------
// grf_pkg: shared types and constants of the gapped run finder
// Transaction payload structs, register indexes and counter limits.
// ----------------------------------------------------------------------------
`default_nettype none

package grf_pkg;

    localparam int unsigned CFG_W   = 9;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned DOC_W   = 32;
    localparam int unsigned POS8_W  = 8;

    localparam logic [COUNT_W-1:0] COUNT_SAT = 9'd511;

    localparam logic [CFG_W-1:0] HIT_CAP_RESET     = 9'd16;
    localparam logic [CFG_W-1:0] MIN_HIT_LEN_RESET = 9'd3;

    typedef enum logic [0:0] {
        REG_HIT_CAP     = 1'b0,
        REG_MIN_HIT_LEN = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [DOC_W-1:0] doc_id;
        logic             pos_bit;
        logic             end_of_doc;
        logic             end_of_scan;
    } in_item_t;

    typedef struct packed {
        logic [DOC_W-1:0]   best_doc_id;
        logic [POS8_W-1:0]  first_pos;
        logic [POS8_W-1:0]  last_pos;
        logic [COUNT_W-1:0] hit_count;
        logic               found;
    } out_item_t;

endpackage

`default_nettype wire

[design/grf_run_tracker.sv]
// ----------------------------------------------------------------------------
// grf_run_tracker: run tracking and best-run selection
// Updates the open and best runs for one bitmap bit per enabled cycle unless
// frozen, and forms the report from the state left after that bit.
// ----------------------------------------------------------------------------
`default_nettype none

module grf_run_tracker #(
    parameter int unsigned POSITIONS = 256
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          en,
    input  grf_pkg::in_item_t            item,
    input  wire [grf_pkg::CFG_W-1:0]     hit_cap,
    input  wire [grf_pkg::CFG_W-1:0]     min_hit_len,
    output grf_pkg::out_item_t           result
);
    import grf_pkg::*;

    localparam int unsigned PW = (POSITIONS > 2) ? $clog2(POSITIONS) : 1;
    localparam int unsigned EW = PW + 8;
    localparam logic [PW-1:0] LAST_POS = PW'(POSITIONS - 1);

    logic [PW-1:0]      pos_reg, pos_next;
    logic [COUNT_W-1:0] cur_count_reg, cur_count_next;
    logic [POS8_W-1:0]  cur_start_reg, cur_start_next;
    logic [POS8_W-1:0]  cur_clip_reg, cur_clip_next;
    logic               gap_reg, gap_next;
    logic [COUNT_W-1:0] best_count_reg, best_count_next;
    logic [POS8_W-1:0]  best_start_reg, best_start_next;
    logic [POS8_W-1:0]  best_clip_reg, best_clip_next;
    logic [DOC_W-1:0]   best_doc_reg, best_doc_next;
    logic               frozen_reg, frozen_next;

    logic [EW-1:0]      pos_ext;
    logic [POS8_W-1:0]  p8;
    logic [COUNT_W-1:0] run_count;
    logic [POS8_W-1:0]  run_start;
    logic [POS8_W-1:0]  run_clip;
    logic               doc_end;
    logic               close_run;
    logic [COUNT_W-1:0] hits;

    assign pos_ext = EW'(pos_reg);
    assign p8      = pos_ext[POS8_W-1:0];

    always_comb begin
        run_count = cur_count_reg;
        run_start = cur_start_reg;
        run_clip  = cur_clip_reg;
        if (item.pos_bit) begin
            if (cur_count_reg == '0) begin
                run_start = p8;
            end
            if (cur_count_reg < hit_cap) begin
                run_clip = p8;
            end
            if (cur_count_reg != COUNT_SAT) begin
                run_count = cur_count_reg + COUNT_W'(1);
            end
        end
    end

    assign doc_end   = item.end_of_doc || item.end_of_scan || (pos_reg == LAST_POS);
    assign close_run = doc_end || (!item.pos_bit && gap_reg);

    always_comb begin
        pos_next        = pos_reg;
        cur_count_next  = cur_count_reg;
        cur_start_next  = cur_start_reg;
        cur_clip_next   = cur_clip_reg;
        gap_next        = gap_reg;
        best_count_next = best_count_reg;
        best_start_next = best_start_reg;
        best_clip_next  = best_clip_reg;
        best_doc_next   = best_doc_reg;
        frozen_next     = frozen_reg;
        if (!frozen_reg) begin
            cur_count_next = run_count;
            cur_start_next = run_start;
            cur_clip_next  = run_clip;
            gap_next       = !item.pos_bit && !doc_end;
            pos_next       = doc_end ? '0 : pos_reg + PW'(1);
            if (close_run) begin
                if (run_count > best_count_reg) begin
                    best_count_next = run_count;
                    best_start_next = run_start;
                    best_clip_next  = run_clip;
                    best_doc_next   = item.doc_id;
                end
                cur_count_next = '0;
                cur_start_next = '0;
                cur_clip_next  = '0;
            end
            frozen_next = doc_end && (best_count_next > hit_cap);
        end
    end

    assign hits = (best_count_next < hit_cap) ? best_count_next : hit_cap;

    always_comb begin
        result.best_doc_id = best_doc_next;
        result.first_pos   = (best_count_next != '0) ? best_start_next : '0;
        result.last_pos    = (hits != '0) ? best_clip_next : '0;
        result.hit_count   = hits;
        result.found       = (best_count_next >= min_hit_len);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (en && item.end_of_scan)) begin
            pos_reg        <= '0;
            cur_count_reg  <= '0;
            cur_start_reg  <= '0;
            cur_clip_reg   <= '0;
            gap_reg        <= 1'b0;
            best_count_reg <= '0;
            best_start_reg <= '0;
            best_clip_reg  <= '0;
            best_doc_reg   <= '0;
            frozen_reg     <= 1'b0;
        end else if (en) begin
            pos_reg        <= pos_next;
            cur_count_reg  <= cur_count_next;
            cur_start_reg  <= cur_start_next;
            cur_clip_reg   <= cur_clip_next;
            gap_reg        <= gap_next;
            best_count_reg <= best_count_next;
            best_start_reg <= best_start_next;
            best_clip_reg  <= best_clip_next;
            best_doc_reg   <= best_doc_next;
            frozen_reg     <= frozen_next;
        end
    end

endmodule

`default_nettype wire

[design/gapped_run_finder.sv]
// Report: an end-of-scan transaction is held in the input register, and its report
// is loaded into the output register once that register is empty or m_ready is high.
// Throughput: one bitmap bit per cycle; the input register refills while a
// report waits in the output register, and only an end-of-scan bit waits for it.
// Reset: aresetn is synchronous and active low; it clears run state, both
// pipeline valids, and sets the hit cap to 16 and min_hit_len to 3.
// ----------------------------------------------------------------------------
// gapped_run_finder: longest gapped run of set bits across document bitmaps
// Input register, run tracker and report register, with configuration
// registers written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module gapped_run_finder #(
    parameter int unsigned POSITIONS = 256
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  grf_pkg::in_item_t            s_data,
    output logic                         m_valid,
    input  wire                          m_ready,
    output grf_pkg::out_item_t           m_data,
    input  wire                          cfg_we,
    input  wire                          cfg_addr,
    input  wire [grf_pkg::CFG_W-1:0]     cfg_wdata
);
    import grf_pkg::*;

    logic             in_valid_reg, in_valid_next;
    in_item_t         in_data_reg;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg;
    logic [CFG_W-1:0] hit_cap_reg;
    logic [CFG_W-1:0] min_hit_len_reg;
    logic             advance;
    out_item_t        result;

    assign advance = in_valid_reg && (!in_data_reg.end_of_scan || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && in_data_reg.end_of_scan) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance && in_data_reg.end_of_scan) begin
            out_data_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_cap_reg     <= HIT_CAP_RESET;
            min_hit_len_reg <= MIN_HIT_LEN_RESET;
        end else if (cfg_we) begin
            unique case (reg_index_t'(cfg_addr))
                REG_HIT_CAP:     hit_cap_reg     <= cfg_wdata;
                REG_MIN_HIT_LEN: min_hit_len_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    grf_run_tracker #(
        .POSITIONS(POSITIONS)
    ) u_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (advance),
        .item       (in_data_reg),
        .hit_cap    (hit_cap_reg),
        .min_hit_len(min_hit_len_reg),
        .result     (result)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

[design/grf_checker.sv]
// ----------------------------------------------------------------------------
// grf_checker: port-level checks for the gapped run finder
// Watches the top-level ports over time and is bound to every instance.
// ----------------------------------------------------------------------------
`default_nettype none

module grf_checker (
    input wire                   aclk,
    input wire                   aresetn,
    input wire                   s_ready,
    input wire                   m_valid,
    input wire                   m_ready,
    input grf_pkg::out_item_t    m_data
);
    import grf_pkg::*;

    // The output register is empty after reset.
    a_reset_out_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // The input register is empty after reset, so a transaction can be taken.
    a_reset_in_ready: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("s_ready low after reset");

    // A stalled report holds its transaction.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("report changed while stalled");

    // With no reported hits the last position is zero.
    a_no_hits_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.hit_count == '0) |-> m_data.last_pos == '0)
        else $error("last_pos set without hits");

endmodule

bind gapped_run_finder grf_checker u_grf_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

`default_nettype wire
